// File: rtl/core/sstrap_pkg.sv
package sstrap_pkg;

  localparam int TimeWidthDefault = 24;
  localparam int DistW  = 22;
  localparam int SpeedW = 20;
  localparam int PosW   = 23;
  localparam int MspW   = 21;
  localparam int ThrW   = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 22;

  localparam logic [CfgIdxW-1:0] REG_TOTAL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_SCAN  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SPEED = 2'd2;

  localparam logic [DistW-1:0]  TOTAL_RESET = 22'd1500000;
  localparam logic [DistW-1:0]  SCAN_RESET  = 22'd200000;
  localparam logic [SpeedW-1:0] SPEED_RESET = 20'd150000;

  localparam logic [SpeedW-1:0] HOMING_SPEED = 20'd25000;
  localparam logic signed [MspW-1:0] STOP_SPEED_LIMIT = 21'sd10000;

  localparam logic [ThrW-1:0] THR_RESET = 8'd200;
  localparam logic [ThrW-1:0] THR_HOME  = 8'd40;
  localparam logic [ThrW-1:0] THR_RUN   = 8'd10;
  localparam logic [ThrW-1:0] THR_STOP  = 8'd5;

  typedef enum logic [2:0] {
    M_WAIT    = 3'd0,
    M_HOME    = 3'd1,
    M_ACCEL   = 3'd2,
    M_SCAN    = 3'd3,
    M_DECEL   = 3'd4,
    M_STOPPED = 3'd5,
    M_SAFE    = 3'd6
  } mode_t;

  // datapath jobs
  typedef enum logic [1:0] {
    OP_NONE    = 2'd0,
    OP_PROFILE = 2'd1,
    OP_SPEED   = 2'd2
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_sts_t;

endpackage

// File: rtl/core/sstrap_if.sv
interface sstrap_in_if;
  logic                       valid;
  logic                       ready;
  logic                       stop_pin;
  logic                       start_request;
  logic                       stall_error;
  logic signed [22:0]         position_um;
  logic signed [20:0]         measured_speed_um_s;
  modport source (output valid, stop_pin, start_request, stall_error, position_um,
                  measured_speed_um_s, input ready);
  modport sink (input valid, stop_pin, start_request, stall_error, position_um,
                measured_speed_um_s, output ready);
endinterface

interface sstrap_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  state_code;
  logic [19:0] speed_cmd_um_s;
  logic        direction;
  logic        run_enable;
  logic [7:0]  stall_threshold;
  logic        scan_window;
  logic        reset_position;
  logic        clear_error;
  modport source (output valid, state_code, speed_cmd_um_s, direction, run_enable,
                  stall_threshold, scan_window, reset_position, clear_error,
                  input ready);
  modport sink (input valid, state_code, speed_cmd_um_s, direction, run_enable,
                stall_threshold, scan_window, reset_position, clear_error,
                output ready);
endinterface

interface sstrap_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [21:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/sstrap_datapath.sv
// Shared restoring divider plus profile registers.
// OP_PROFILE: two divides (ramp, hold) latch the profile.
// OP_SPEED: on a ramp one multiply, one divide; else speed set directly.
module sstrap_datapath #(
  parameter int TIME_WIDTH = sstrap_pkg::TimeWidthDefault
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sstrap_pkg::dp_cmd_t                 cmd,
  output sstrap_pkg::dp_sts_t                 sts,
  input  logic [sstrap_pkg::DistW-1:0]        total_um,
  input  logic [sstrap_pkg::DistW-1:0]        scan_um,
  input  logic [sstrap_pkg::SpeedW-1:0]       speed_um_s,
  input  logic [TIME_WIDTH-1:0]               elapsed,
  output logic [sstrap_pkg::DistW-1:0]        ramp_dist,
  output logic [sstrap_pkg::SpeedW-1:0]       prof_speed
);
  import sstrap_pkg::*;

  // numerators: 1000*4e6 < 2^32; v*e < 2^(20+TIME_WIDTH)
  localparam int NumW = (SpeedW + TIME_WIDTH > 32) ? SpeedW + TIME_WIDTH : 32;
  localparam int DenW = (TIME_WIDTH > SpeedW) ? TIME_WIDTH : SpeedW;
  localparam int CntW = $clog2(NumW + 1);
  localparam logic [TIME_WIDTH-1:0] TimeMax = {TIME_WIDTH{1'b1}};

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RAMP  = 6'b000010,
    S_HOLD  = 6'b000100,
    S_MUL   = 6'b001000,
    S_SDIV  = 6'b010000,
    S_DIV   = 6'b100000
  } dst_t;

  dst_t state_r, state_nxt;

  logic [NumW-1:0] quo_r, quo_nxt;      // numerator shifting into quotient
  logic [DenW:0]   rem_r, rem_nxt;
  logic [DenW-1:0] den_r, den_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [TIME_WIDTH-1:0] ramp_t_r, ramp_t_nxt, hold_t_r, hold_t_nxt;
  logic [DistW-1:0] ramp_d_r, ramp_d_nxt;
  logic [SpeedW-1:0] spd_r, spd_nxt;
  logic [NumW-1:0] prod_r, prod_nxt;
  logic [TIME_WIDTH-1:0] mul_t_r, mul_t_nxt;

  logic [DistW-1:0]  diff;
  logic [DenW:0]     rem_sh, rem_sub;
  logic              fits;
  logic [NumW-1:0]   q_final;
  logic [TIME_WIDTH-1:0] q_sat;
  logic [TIME_WIDTH+1:0] r1, r1h, r2h;
  logic [TIME_WIDTH+1:0] e_ext;
  logic [TIME_WIDTH-1:0] t_down;

  assign diff = (total_um > scan_um) ? total_um - scan_um : '0;

  assign rem_sh  = {rem_r[DenW-1:0], quo_r[NumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign fits    = !rem_sub[DenW];
  assign q_final = {quo_r[NumW-2:0], fits};
  assign q_sat   = (q_final > NumW'(TimeMax)) ? TimeMax : q_final[TIME_WIDTH-1:0];

  assign e_ext = {2'b00, elapsed};
  assign r1    = {2'b00, ramp_t_r};
  assign r1h   = r1 + {2'b00, hold_t_r};
  assign r2h   = r1h + r1;
  // r - (e - r - h) = 2r + h - e, valid only in the falling segment
  assign t_down = TIME_WIDTH'(r2h - e_ext);

  assign sts.busy = (state_r != S_IDLE);
  assign ramp_dist = ramp_d_r;
  assign prof_speed = spd_r;

  always_comb begin
    state_nxt = state_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    ramp_t_nxt = ramp_t_r;
    hold_t_nxt = hold_t_r;
    ramp_d_nxt = ramp_d_r;
    spd_nxt = spd_r;
    prod_nxt = prod_r;
    mul_t_nxt = mul_t_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start && cmd.op == OP_PROFILE) begin
          ramp_d_nxt = diff >> 1;
          quo_nxt = NumW'(diff) * NumW'(1000);
          rem_nxt = '0;
          den_nxt = DenW'(speed_um_s);
          cnt_nxt = CntW'(NumW - 1);
          state_nxt = S_RAMP;
        end else if (cmd.start && cmd.op == OP_SPEED) begin
          if (e_ext < r1) begin
            mul_t_nxt = elapsed;
            state_nxt = S_MUL;
          end else if (e_ext < r1h) begin
            spd_nxt = speed_um_s;
          end else if (e_ext < r2h) begin
            mul_t_nxt = t_down;
            state_nxt = S_MUL;
          end else begin
            spd_nxt = '0;
          end
        end
      end
      S_RAMP, S_HOLD, S_DIV: begin
        rem_nxt = fits ? rem_sub : rem_sh;
        quo_nxt = q_final;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          priority if (state_r == S_RAMP) begin
            ramp_t_nxt = (diff == '0) ? '0 : (den_r == '0) ? TimeMax : q_sat;
            quo_nxt = NumW'(scan_um) * NumW'(1000);
            rem_nxt = '0;
            cnt_nxt = CntW'(NumW - 1);
            state_nxt = S_HOLD;
          end else if (state_r == S_HOLD) begin
            hold_t_nxt = (scan_um == '0) ? '0 : (den_r == '0) ? TimeMax : q_sat;
            state_nxt = S_IDLE;
          end else begin
            spd_nxt = SpeedW'(q_final);
            state_nxt = S_IDLE;
          end
        end
      end
      S_MUL: begin
        prod_nxt = NumW'(speed_um_s) * NumW'(mul_t_r);
        state_nxt = S_SDIV;
      end
      S_SDIV: begin
        quo_nxt = prod_r;
        rem_nxt = '0;
        den_nxt = DenW'(ramp_t_r);
        cnt_nxt = CntW'(NumW - 1);
        state_nxt = S_DIV;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ramp_t_r <= '0;
      hold_t_r <= '0;
      ramp_d_r <= '0;
      spd_r <= '0;
    end else begin
      state_r <= state_nxt;
      ramp_t_r <= ramp_t_nxt;
      hold_t_r <= hold_t_nxt;
      ramp_d_r <= ramp_d_nxt;
      spd_r <= spd_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    prod_r <= prod_nxt;
    mul_t_r <= mul_t_nxt;
  end

endmodule

// File: rtl/core/sstrap_ctrl.sv
// Mode sequencer: takes one tick word, runs the datapath as needed, emits one word.
module sstrap_ctrl #(
  parameter int TIME_WIDTH = sstrap_pkg::TimeWidthDefault
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   stop_pin,
  input  logic                                   start_request,
  input  logic                                   stall_error,
  input  logic signed [sstrap_pkg::PosW-1:0]     position_um,
  input  logic signed [sstrap_pkg::MspW-1:0]     measured_speed_um_s,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [2:0]                             state_code,
  output logic [sstrap_pkg::SpeedW-1:0]          speed_cmd,
  output logic                                   direction,
  output logic                                   run_enable,
  output logic [sstrap_pkg::ThrW-1:0]            stall_threshold,
  output logic                                   scan_window,
  output logic                                   reset_position,
  output logic                                   clear_error,
  input  logic [sstrap_pkg::DistW-1:0]           total_um,
  input  logic [sstrap_pkg::DistW-1:0]           ramp_dist,
  input  logic [sstrap_pkg::SpeedW-1:0]          prof_speed,
  output logic [TIME_WIDTH-1:0]                  elapsed,
  output sstrap_pkg::dp_cmd_t                    cmd,
  input  sstrap_pkg::dp_sts_t                    sts
);
  import sstrap_pkg::*;

  localparam logic [TIME_WIDTH-1:0] TimeMax = {TIME_WIDTH{1'b1}};

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_LAUNCH = 4'b0010,
    C_WAIT = 4'b0100,
    C_EMIT = 4'b1000
  } cst_t;

  cst_t state_r, state_nxt;
  mode_t mode_r, mode_nxt;
  logic [TIME_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic last_pin_r, last_pin_nxt, dir_r, dir_nxt;
  logic [ThrW-1:0] thr_r, thr_nxt;
  op_t op_r, op_nxt;
  logic speed_sel_r, speed_sel_nxt;        // take the profile speed
  logic [SpeedW-1:0] spd_r, spd_nxt;
  logic run_r, run_nxt, win_r, win_nxt, rstp_r, rstp_nxt, clre_r, clre_nxt;
  logic ovalid_r, ovalid_nxt;

  logic signed [DistW+1:0] pos_x, rd_x, hi_x;
  logic signed [MspW-1:0] msp;
  logic window;

  assign pos_x = (DistW + 2)'(position_um);
  assign rd_x = {2'b00, ramp_dist};
  assign hi_x = {2'b00, total_um} - rd_x;
  assign window = (pos_x > rd_x) && (pos_x < hi_x);
  assign msp = measured_speed_um_s;

  assign in_ready = (state_r == C_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign state_code = mode_r;
  assign speed_cmd = speed_sel_r ? prof_speed : spd_r;
  assign direction = dir_r;
  assign run_enable = run_r;
  assign stall_threshold = thr_r;
  assign scan_window = win_r;
  assign reset_position = rstp_r;
  assign clear_error = clre_r;
  assign elapsed = elapsed_r;
  assign cmd.op = op_r;
  assign cmd.start = (state_r == C_LAUNCH);

  always_comb begin
    state_nxt = state_r;
    mode_nxt = mode_r;
    elapsed_nxt = elapsed_r;
    last_pin_nxt = last_pin_r;
    dir_nxt = dir_r;
    thr_nxt = thr_r;
    op_nxt = op_r;
    speed_sel_nxt = speed_sel_r;
    spd_nxt = spd_r;
    run_nxt = run_r;
    win_nxt = win_r;
    rstp_nxt = rstp_r;
    clre_nxt = clre_r;
    ovalid_nxt = ovalid_r;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      C_IDLE: begin
        if (in_valid && in_ready) begin
          win_nxt = window;
          spd_nxt = '0;
          run_nxt = 1'b0;
          rstp_nxt = 1'b0;
          clre_nxt = 1'b0;
          speed_sel_nxt = 1'b0;
          op_nxt = OP_NONE;
          state_nxt = C_EMIT;
          if (stop_pin != last_pin_r) begin
            last_pin_nxt = stop_pin;
            mode_nxt = M_SAFE;
          end else begin
            unique case (mode_r)
              M_WAIT: begin
                if (start_request) begin
                  dir_nxt = 1'b0;
                  thr_nxt = THR_HOME;
                  mode_nxt = M_HOME;
                end
              end
              M_HOME: begin
                if (stall_error) begin
                  clre_nxt = 1'b1;
                  rstp_nxt = 1'b1;
                  dir_nxt = 1'b1;
                  thr_nxt = THR_RUN;
                  elapsed_nxt = '0;
                  mode_nxt = M_ACCEL;
                  op_nxt = OP_PROFILE;
                  state_nxt = C_LAUNCH;
                end else begin
                  spd_nxt = HOMING_SPEED;
                  run_nxt = 1'b1;
                end
              end
              M_ACCEL, M_SCAN, M_DECEL: begin
                run_nxt = 1'b1;
                speed_sel_nxt = 1'b1;
                op_nxt = OP_SPEED;
                state_nxt = C_LAUNCH;
                if (mode_r == M_ACCEL && window) begin
                  dir_nxt = 1'b1;
                  thr_nxt = THR_RUN;
                  mode_nxt = M_SCAN;
                end else if (mode_r == M_SCAN && !window) begin
                  dir_nxt = 1'b1;
                  thr_nxt = THR_RUN;
                  mode_nxt = M_DECEL;
                end else if (mode_r == M_DECEL && msp < STOP_SPEED_LIMIT) begin
                  dir_nxt = 1'b0;
                  thr_nxt = THR_STOP;
                  mode_nxt = M_STOPPED;
                end
              end
              M_STOPPED: begin
                elapsed_nxt = '0;
                mode_nxt = M_WAIT;
              end
              default: begin
                mode_nxt = M_SAFE;
                if (!stop_pin) begin
                  clre_nxt = 1'b1;
                  rstp_nxt = 1'b1;
                  elapsed_nxt = '0;
                  mode_nxt = M_WAIT;
                end
              end
            endcase
          end
        end
      end
      C_LAUNCH: state_nxt = C_WAIT;
      C_WAIT: begin
        if (!sts.busy) begin
          // elapsed steps only after the speed lookup used it
          if (op_r == OP_SPEED && elapsed_r != TimeMax) elapsed_nxt = elapsed_r + 1'b1;
          state_nxt = C_EMIT;
        end
      end
      C_EMIT: begin
        ovalid_nxt = 1'b1;
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      mode_r <= M_SAFE;
      elapsed_r <= '0;
      last_pin_r <= 1'b0;
      dir_r <= 1'b0;
      thr_r <= THR_RESET;
      ovalid_r <= 1'b0;
      op_r <= OP_NONE;
    end else begin
      state_r <= state_nxt;
      mode_r <= mode_nxt;
      elapsed_r <= elapsed_nxt;
      last_pin_r <= last_pin_nxt;
      dir_r <= dir_nxt;
      thr_r <= thr_nxt;
      ovalid_r <= ovalid_nxt;
      op_r <= op_nxt;
    end
    speed_sel_r <= speed_sel_nxt;
    spd_r <= spd_nxt;
    run_r <= run_nxt;
    win_r <= win_nxt;
    rstp_r <= rstp_nxt;
    clre_r <= clre_nxt;
  end

endmodule

// File: rtl/core/scan_stage_trapezoid_sequencer.sv
// Channel | Dir | Words
// in_     | in  | one tick: stop_pin, start_request, stall_error, position, speed
// out_    | out | one result word per tick word
// cfg_    | in  | index 0 total, 1 scan length, 2 scan speed
//
// Work per tick: in idle modes the datapath is not used; on the flat or finished
// part of the profile it is launched but sets the speed directly; the ramp speed
// takes a multiply plus one serial divide of NUM_W bits; the end of homing takes
// two divides. NUM_W, the width of the shared one-bit-per-cycle divider, is
// max(32, 20+TIME_WIDTH).
// Reset: synchronous rst_n, mode safe stop, config registers at their defaults.
// Stalls: a result held on out_ blocks the next tick; cfg_ is always ready.
module scan_stage_trapezoid_sequencer #(
  parameter int TIME_WIDTH = sstrap_pkg::TimeWidthDefault
) (
  input logic clk,
  input logic rst_n,
  sstrap_in_if.sink    in_ch,
  sstrap_out_if.source out_ch,
  sstrap_cfg_if.sink   cfg_ch
);
  import sstrap_pkg::*;

  logic [DistW-1:0]  total_r, scan_r;
  logic [SpeedW-1:0] speed_r;
  logic [DistW-1:0]  ramp_dist;
  logic [SpeedW-1:0] prof_speed;
  logic [TIME_WIDTH-1:0] elapsed;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration registers, the user writes them between ticks; the block itself does not enforce it
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= TOTAL_RESET;
      scan_r <= SCAN_RESET;
      speed_r <= SPEED_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_TOTAL: total_r <= cfg_ch.data;
        REG_SCAN:  scan_r <= cfg_ch.data;
        REG_SPEED: speed_r <= cfg_ch.data[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  sstrap_ctrl #(.TIME_WIDTH(TIME_WIDTH)) u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .stop_pin(in_ch.stop_pin), .start_request(in_ch.start_request),
    .stall_error(in_ch.stall_error), .position_um(in_ch.position_um),
    .measured_speed_um_s(in_ch.measured_speed_um_s),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .state_code(out_ch.state_code), .speed_cmd(out_ch.speed_cmd_um_s),
    .direction(out_ch.direction), .run_enable(out_ch.run_enable),
    .stall_threshold(out_ch.stall_threshold), .scan_window(out_ch.scan_window),
    .reset_position(out_ch.reset_position), .clear_error(out_ch.clear_error),
    .total_um(total_r), .ramp_dist, .prof_speed, .elapsed, .cmd, .sts
  );

  sstrap_datapath #(.TIME_WIDTH(TIME_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .total_um(total_r), .scan_um(scan_r), .speed_um_s(speed_r),
    .elapsed, .ramp_dist, .prof_speed
  );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sstrap_pkg::*;

  localparam int          CYCLE_LIMIT = 1_500_000;
  localparam int          DRAIN_CYCLES = 100;
  localparam longint      TMAX = 64'hFF_FFFF;   // all-ones of a 24 bit time value
  localparam int          RANDOM_WORDS = 1350;

  // one result word of the sequencer
  typedef struct packed {
    logic [2:0]  state_code;
    logic [19:0] speed_cmd_um_s;
    logic        direction;
    logic        run_enable;
    logic [7:0]  stall_threshold;
    logic        scan_window;
    logic        reset_position;
    logic        clear_error;
  } tick_res_t;

  // one row of the directed table; typed rows carry their result
  typedef struct {
    bit               pin;
    bit               start;
    bit               stall;
    logic [22:0]      pos;
    logic [20:0]      msp;
    bit               typed;
    tick_res_t        res;
  } tick_row_t;

  logic clk;
  logic rst_n;

  sstrap_in_if  in_ch ();
  sstrap_out_if out_ch ();
  sstrap_cfg_if cfg_ch ();

  scan_stage_trapezoid_sequencer uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the sequencer: configuration and state, updated per accepted word
  // ---------------------------------------------------------------------------
  longint    total_um, scan_um, speed_cfg;
  mode_t     seq_mode;
  longint    elapsed, ramp_dist, ramp_ms, hold_ms;
  bit        last_pin, dir_q;
  logic [7:0] thr_q;

  tick_res_t expected_words[$];
  int        mismatches;
  int        tx_idle_pct, rx_idle_pct;
  int        hold_off_req;
  int        cycle_cnt;

  function automatic longint sat_div(longint num, longint den);
    longint q;
    if (den == 0) begin
      return TMAX;
    end
    q = num / den;
    return (q > TMAX) ? TMAX : q;
  endfunction

  // Profile latched when homing ends on a stall
  function automatic void latch_trapezoid();
    longint diff;
    diff = (total_um > scan_um) ? total_um - scan_um : 0;
    ramp_dist = diff / 2;
    ramp_ms   = (diff == 0) ? 0 : sat_div(1000 * diff, speed_cfg);
    hold_ms   = (scan_um == 0) ? 0 : sat_div(1000 * scan_um, speed_cfg);
  endfunction

  // Speed command at elapsed time e; level follows the live speed register
  function automatic longint ramp_speed(longint e);
    if (e < ramp_ms) begin
      return speed_cfg * e / ramp_ms;
    end
    if (e < ramp_ms + hold_ms) begin
      return speed_cfg;
    end
    if (e < 2 * ramp_ms + hold_ms) begin
      return speed_cfg * (ramp_ms - (e - ramp_ms - hold_ms)) / ramp_ms;
    end
    return 0;
  endfunction

  function automatic tick_res_t stage_step(bit pin, bit start, bit stall,
                                           logic [22:0] pos_raw, logic [20:0] msp_raw);
    tick_res_t r;
    longint    pos, msp, spd;
    bit        run, rp, ce, win;
    pos = longint'($signed(pos_raw));
    msp = longint'($signed(msp_raw));
    spd = 0;
    run = 0;
    rp  = 0;
    ce  = 0;
    // window uses the ramp distance held at the start of the tick
    win = (pos > ramp_dist) && (pos < total_um - ramp_dist);
    if (pin != last_pin) begin
      // stop pin edge: safe stop, nothing else this tick
      last_pin = pin;
      seq_mode = M_SAFE;
    end else begin
      case (seq_mode)
        M_WAIT: begin
          if (start) begin
            dir_q    = 1'b0;
            thr_q    = THR_HOME;
            seq_mode = M_HOME;
          end
        end
        M_HOME: begin
          if (stall) begin
            ce = 1;
            rp = 1;
            latch_trapezoid();
            dir_q    = 1'b1;
            thr_q    = THR_RUN;
            elapsed  = 0;
            seq_mode = M_ACCEL;
          end else begin
            spd = HOMING_SPEED;
            run = 1;
          end
        end
        M_ACCEL, M_SCAN, M_DECEL: begin
          run = 1;
          spd = ramp_speed(elapsed);
          if (elapsed < TMAX) begin
            elapsed++;
          end
          if (seq_mode == M_ACCEL && win) begin
            dir_q    = 1'b1;
            thr_q    = THR_RUN;
            seq_mode = M_SCAN;
          end else if (seq_mode == M_SCAN && !win) begin
            dir_q    = 1'b1;
            thr_q    = THR_RUN;
            seq_mode = M_DECEL;
          end else if (seq_mode == M_DECEL && msp < 10000) begin
            dir_q    = 1'b0;
            thr_q    = THR_STOP;
            seq_mode = M_STOPPED;
          end
        end
        M_STOPPED: begin
          elapsed  = 0;
          seq_mode = M_WAIT;
        end
        default: begin
          seq_mode = M_SAFE;
          if (!pin) begin
            ce = 1;
            rp = 1;
            elapsed  = 0;
            seq_mode = M_WAIT;
          end
        end
      endcase
    end
    r.state_code      = seq_mode;
    r.speed_cmd_um_s  = spd[19:0];
    r.direction       = dir_q;
    r.run_enable      = run;
    r.stall_threshold = thr_q;
    r.scan_window     = win;
    r.reset_position  = rp;
    r.clear_error     = ce;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one tick word; valid stays high into the next word unless a gap comes
  task automatic send_tick(bit pin, bit start, bit stall, logic [22:0] pos,
                           logic [20:0] msp, bit typed, tick_res_t typed_res);
    tick_res_t r;
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid               <= 1'b1;
    in_ch.stop_pin            <= pin;
    in_ch.start_request       <= start;
    in_ch.stall_error         <= stall;
    in_ch.position_um         <= pos;
    in_ch.measured_speed_um_s <= msp;
    do @(posedge clk); while (!in_ch.ready);
    r = stage_step(pin, start, stall, pos, msp);
    expected_words.push_back(typed ? typed_res : r);
  endtask

  task automatic write_reg(logic [1:0] idx, longint val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[21:0];
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_TOTAL: total_um  = val & 64'h3F_FFFF;
      REG_SCAN:  scan_um   = val & 64'h3F_FFFF;
      REG_SPEED: speed_cfg = val & 64'hF_FFFF;
      default: ;
    endcase
  endtask

  // Block idle: input quiet, every result back, then a margin for the datapath
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls plus a long hold-off on request
  int hold_left;
  always @(posedge clk) begin
    if (hold_off_req != 0 && hold_left == 0) begin
      hold_left <= hold_off_req;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    out_ch.ready <= (hold_left <= 1) && ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    tick_res_t got, exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.state_code, out_ch.speed_cmd_um_s, out_ch.direction,
             out_ch.run_enable, out_ch.stall_threshold, out_ch.scan_window,
             out_ch.reset_position, out_ch.clear_error};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word: %p", got);
        end
      end else begin
        exp_w = expected_words.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp %p", exp_w);
            $display("          got %p", got);
          end
        end
      end
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Directed ticks starting from reset defaults (total 1.5 m, scan 0.2 m).
  // After the stall the window runs 650000 < pos < 850000.
  tick_row_t dir_rows[] = '{
    // leave safe stop after reset
    '{0, 0, 0, 23'd5,       21'd0, 1, '{M_WAIT, 20'd0, 1'b0, 1'b0, THR_RESET, 1'b1, 1'b1, 1'b1}},
    // waiting, no start
    '{0, 0, 1, 23'h40_0000, 21'd0, 1, '{M_WAIT, 20'd0, 1'b0, 1'b0, THR_RESET, 1'b0, 1'b0, 1'b0}},
    '{0, 1, 0, 23'd0,       21'd0, 1, '{M_HOME, 20'd0, 1'b0, 1'b0, THR_HOME, 1'b0, 1'b0, 1'b0}},
    '{0, 1, 0, 23'h3F_FFFF, 21'h0F_FFFF, 1,
      '{M_HOME, HOMING_SPEED, 1'b0, 1'b1, THR_HOME, 1'b0, 1'b0, 1'b0}},
    '{0, 0, 1, 23'd0,       21'd0, 1, '{M_ACCEL, 20'd0, 1'b1, 1'b0, THR_RUN, 1'b0, 1'b1, 1'b1}},
    '{0, 0, 0, 23'd100,     21'd0, 0, '0},
    '{0, 0, 0, 23'd650000,  21'd0, 0, '0},   // on the lower edge, still outside
    '{0, 0, 0, 23'd700000,  21'd0, 0, '0},   // into scanning
    '{0, 0, 0, 23'd849999,  21'd0, 0, '0},
    '{0, 0, 0, 23'd850000,  21'd0, 0, '0},   // upper edge: decelerating
    '{0, 0, 0, 23'd900000,  21'h0F_FFFF, 0, '0},
    '{0, 0, 0, 23'd900000,  21'd10000, 0, '0},
    '{0, 0, 0, 23'd900000,  21'h10_0000, 0, '0},   // most negative speed: stopped
    '{0, 0, 0, 23'd0,       21'd0, 0, '0},           // stopped to waiting
    // stop pin edge from waiting
    '{1, 1, 1, 23'd0,       21'd0, 1, '{M_SAFE, 20'd0, 1'b0, 1'b0, THR_STOP, 1'b0, 1'b0, 1'b0}},
    // pin held high keeps safe stop
    '{1, 1, 1, 23'd0,       21'd0, 1, '{M_SAFE, 20'd0, 1'b0, 1'b0, THR_STOP, 1'b0, 1'b0, 1'b0}},
    // falling edge is a change too
    '{0, 0, 0, 23'd0,       21'd0, 1, '{M_SAFE, 20'd0, 1'b0, 1'b0, THR_STOP, 1'b0, 1'b0, 1'b0}},
    '{0, 0, 0, 23'd0,       21'd0, 1, '{M_WAIT, 20'd0, 1'b0, 1'b0, THR_STOP, 1'b0, 1'b1, 1'b1}},
    '{0, 1, 0, 23'd0,       21'd0, 0, '0},
    '{1, 0, 1, 23'd0,       21'd0, 0, '0}     // pin edge during homing beats the stall
  };

  // Position biased toward the window and its edges
  function automatic logic [22:0] pick_pos();
    longint lo, hi;
    lo = ramp_dist;
    hi = total_um - ramp_dist;
    case ($urandom_range(5, 0))
      0:       return $urandom;
      1:       return lo + $urandom_range(2, 0) - 1;
      2:       return hi + $urandom_range(2, 0) - 1;
      3:       return $urandom_range(64, 0);
      default: return (hi > lo + 1) ? lo + 1 + ($urandom % (hi - lo - 1)) : $urandom;
    endcase
  endfunction

  function automatic logic [20:0] pick_msp();
    case ($urandom_range(3, 0))
      0:       return $urandom;
      1:       return 21'd10000 - $urandom_range(2, 0) + 1;
      default: return $urandom_range(30000, 0);
    endcase
  endfunction

  // Register settings per phase: total, scan, speed
  longint phase_cfg[6][3] = '{
    '{3000,    1000,    100000},   // short ramps and hold
    '{4000000, 0,       1000000},  // largest travel, no scan segment
    '{1,       4000000, 1},        // scan longer than total
    '{2000,    400,     40000},
    '{4000000, 3000,    0},        // zero speed saturates the times
    '{4000000, 20000,   1}         // time overflow, saturating ramp and hold
  };

  initial begin
    bit         pin;
    tick_res_t  none;
    int         n;
    int         per_phase;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.stop_pin = 1'b0;
    in_ch.start_request = 1'b0;
    in_ch.stall_error = 1'b0;
    in_ch.position_um = '0;
    in_ch.measured_speed_um_s = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_TOTAL;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    hold_left    = 0;
    hold_off_req = 0;
    cycle_cnt    = 0;
    mismatches   = 0;
    tx_idle_pct  = 14;
    rx_idle_pct  = 81;
    none         = '0;
    total_um  = TOTAL_RESET;
    scan_um   = SCAN_RESET;
    speed_cfg = SPEED_RESET;
    seq_mode  = M_SAFE;
    elapsed   = 0;
    ramp_dist = 0;
    ramp_ms   = 0;
    hold_ms   = 0;
    last_pin  = 0;
    dir_q     = 0;
    thr_q     = THR_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].pin, dir_rows[i].start, dir_rows[i].stall,
                dir_rows[i].pos, dir_rows[i].msp, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random part: phases of register settings, idling regime by progress
    per_phase = RANDOM_WORDS / 6;
    n   = 0;
    pin = last_pin;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(REG_TOTAL, phase_cfg[ph][0]);
      write_reg(REG_SCAN,  phase_cfg[ph][1]);
      write_reg(REG_SPEED, phase_cfg[ph][2]);
      for (int k = 0; k < per_phase; k++) begin
        if (n < RANDOM_WORDS / 3) begin
          tx_idle_pct = 14;
          rx_idle_pct = 81;
        end else if (n < 2 * RANDOM_WORDS / 3) begin
          tx_idle_pct = 81;
          rx_idle_pct = 14;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        // long receiver hold-off while ticks keep coming
        if (k == 10 && (ph == 1 || ph == 5)) begin
          hold_off_req <= 400;
        end else if (k == 11) begin
          hold_off_req <= 0;
        end
        if ($urandom_range(99, 0) < 3) begin
          pin = !pin;
        end
        send_tick(pin, $urandom_range(99, 0) < 40, $urandom_range(99, 0) < 30,
                  pick_pos(), pick_msp(), 0, none);
        n++;
      end
      // settle stop pin low so the next phase starts from a clean exit
      pin = 0;
    end
    // a run with the speed register rewritten mid-profile is not allowed
    // (writes only when idle), so the live-speed case is covered by phases
    // that latch with one speed and keep running after a later write.
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/sstrap_pkg.sv
rtl/core/sstrap_if.sv
rtl/core/sstrap_datapath.sv
rtl/core/sstrap_ctrl.sv
rtl/core/scan_stage_trapezoid_sequencer.sv
verif/tb_top.sv
